@@ rtl/smcn_pkg.sv @@
// Package for the sensor min/max calibrating normaliser.
// Holds widths, level limits, op codes and the sequencer state type.
// No dependencies; used by sensor_minmax_calibrate_normalize.
package smcn_pkg;

	// Default sample width and fixed geometry.
	localparam int SMCN_SAMPLE_BITS = 12;
	localparam int CHANNELS         = 5;
	localparam int CH_W             = $clog2(CHANNELS);
	localparam int LEVEL_BITS       = 12;
	localparam int QBITS            = 10;
	localparam int QIDX_W           = $clog2(QBITS);
	localparam int LEVEL_FULL       = 1000;
	localparam int LEVEL_FLOOR      = 1;
	localparam int OUT_DATA_W       = 8 * ((CHANNELS * LEVEL_BITS + 7) / 8);

	// Channels touched by each calibration op (bit i is channel i).
	localparam logic [CHANNELS-1:0] HORIZ_CHANNELS = 5'b10101;
	localparam logic [CHANNELS-1:0] VERT_CHANNELS  = 5'b01010;

	typedef enum logic [1:0] {
		OP_RUN   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_HORIZ = 2'd2,
		OP_VERT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef logic [LEVEL_BITS-1:0] level_t;

endpackage

@@ rtl/sensor_minmax_calibrate_normalize.sv @@
// Top level of the sensor min/max calibrating normaliser.
// Depends on smcn_pkg for widths, op codes and the sequencer state type.
// Holds the calibration tables, the channel sequencer and the shared divider.

// Each input word carries five raw coil samples and an op code. The clear op
// returns every channel's calibration to maximum zero and minimum all ones; the
// horizontal op widens the running range of the outer and centre channels, the
// vertical op that of the two inner channels, and both echo the raw samples with
// the normalised flag low. The run op maps every sample onto 1..1000 as
// floor(1000*(x-min)/(max-min)), giving 1 at or below the minimum or for an
// empty range and 1000 at or above the maximum, and sets the flag. A single
// restoring divider, one quotient bit per cycle, is shared by the five channels
// under a small sequencer, so the block takes one word at a time: a run word
// needs a setup step for each channel plus a ten-bit divide for each channel
// whose sample lies strictly inside its range, then a write step that hands the
// result to the output register and a return to idle, before the next word can
// be taken. Calibration words go from idle straight to the write step. The
// hand-over waits while the output register still holds an unaccepted word.
// The output register lets a new word be accepted while the previous result
// still waits downstream.
module sensor_minmax_calibrate_normalize
	import smcn_pkg::*;
#(
	parameter int SAMPLE_BITS = SMCN_SAMPLE_BITS,
	localparam int IN_DATA_W  = 8 * ((CHANNELS * SAMPLE_BITS + 7) / 8),
	localparam int REM_W      = SAMPLE_BITS + QBITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// From bit 0 up: sample_outer_left, sample_inner_left, sample_center,
	// sample_inner_right, sample_outer_right, zero padding.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op: 0 run, 1 clear, 2 calibrate horizontal, 3 calibrate vertical.
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// From bit 0 up: level_outer_left, level_inner_left, level_center,
	// level_inner_right, level_outer_right, zero padding.
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// normalized: high when the levels are normalised values.
	output logic                  m_axis_tuser
);

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	state_t state_q, state_d;

	// Calibration tables, one entry per channel.
	sample_t max_q [CHANNELS];
	sample_t min_q [CHANNELS];

	// Word being worked on.
	sample_t x_q   [CHANNELS];
	level_t  lev_q [CHANNELS];
	logic    run_q;

	// Sequencer and divider registers.
	logic [CH_W-1:0]   ch_q;
	logic [QIDX_W-1:0] bit_q;
	logic [REM_W-1:0]  rem_q;
	sample_t           den_q;
	logic [QBITS-1:0]  quo_q;

	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_user_q;
	logic                  out_valid_q;

	sample_t          sample_in [CHANNELS];
	op_t              op_in;
	logic             in_acc;
	logic             out_free;
	sample_t          sel_x, sel_lo, sel_hi;
	logic             special;
	level_t           special_lev;
	logic [REM_W-1:0] num;
	logic [REM_W-1:0] dsh;
	logic             ge;
	logic [QBITS-1:0] quo_nx;
	level_t           div_lev;
	logic             last_ch;
	logic [OUT_DATA_W-1:0] out_pack;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			sample_in[i] = s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	assign op_in         = op_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Operands of the channel that the sequencer points at.
	assign sel_x   = x_q[ch_q];
	assign sel_lo  = min_q[ch_q];
	assign sel_hi  = max_q[ch_q];
	assign last_ch = (ch_q == CH_W'(CHANNELS - 1));

	// Empty range, sample at or below the minimum, or at or above the maximum
	// are settled without the divider.
	assign special     = (sel_hi <= sel_lo) || (sel_x <= sel_lo) || (sel_x >= sel_hi);
	assign special_lev = ((sel_hi <= sel_lo) || (sel_x <= sel_lo)) ?
	                     LEVEL_BITS'(LEVEL_FLOOR) : LEVEL_BITS'(LEVEL_FULL);

	// Dividend 1000*(x-min); the multiply is by a constant, i.e. a few adds.
	assign num = REM_W'(sel_x - sel_lo) * REM_W'(LEVEL_FULL);

	// Shared restoring divider step: try the divisor shifted to the current
	// quotient bit. The quotient stays below 1000, so ten bits suffice.
	assign dsh = REM_W'(den_q) << bit_q;
	assign ge  = (rem_q >= dsh);

	always_comb begin
		quo_nx        = quo_q;
		quo_nx[bit_q] = ge;
	end

	assign div_lev = (quo_nx == '0) ? LEVEL_BITS'(LEVEL_FLOOR) : LEVEL_BITS'(quo_nx);

	always_comb begin
		out_pack = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			out_pack[i*LEVEL_BITS +: LEVEL_BITS] = lev_q[i];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (op_in == OP_RUN) ? ST_SETUP : ST_WRITE;
				end
			end
			ST_SETUP: begin
				if (!special) begin
					state_d = ST_DIV;
				end else if (last_ch) begin
					state_d = ST_WRITE;
				end
			end
			ST_DIV: begin
				if (bit_q == '0) begin
					state_d = last_ch ? ST_WRITE : ST_SETUP;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				ch_q <= '0;
			end else if (state_q == ST_SETUP) begin
				if (special) begin
					ch_q <= ch_q + 1'b1;
				end else begin
					bit_q <= QIDX_W'(QBITS - 1);
				end
			end else if (state_q == ST_DIV) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					ch_q <= ch_q + 1'b1;
				end
			end

			if (state_q == ST_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Calibration tables: cleared by reset and by the clear op.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				max_q[i] <= '0;
				min_q[i] <= '1;
			end
		end else if (in_acc) begin
			unique case (op_in)
				OP_RUN: begin
				end
				OP_CLEAR: begin
					for (int i = 0; i < CHANNELS; i++) begin
						max_q[i] <= '0;
						min_q[i] <= '1;
					end
				end
				OP_HORIZ, OP_VERT: begin
					for (int i = 0; i < CHANNELS; i++) begin
						if ((op_in == OP_HORIZ) ? HORIZ_CHANNELS[i] : VERT_CHANNELS[i]) begin
							if (sample_in[i] > max_q[i]) begin
								max_q[i] <= sample_in[i];
							end
							if (sample_in[i] < min_q[i]) begin
								min_q[i] <= sample_in[i];
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			run_q <= (op_in == OP_RUN);
			for (int i = 0; i < CHANNELS; i++) begin
				x_q[i]   <= sample_in[i];
				lev_q[i] <= LEVEL_BITS'(sample_in[i]);
			end
		end else if (state_q == ST_SETUP) begin
			if (special) begin
				lev_q[ch_q] <= special_lev;
			end else begin
				rem_q <= num;
				den_q <= sel_hi - sel_lo;
				quo_q <= '0;
			end
		end else if (state_q == ST_DIV) begin
			if (ge) begin
				rem_q <= rem_q - dsh;
			end
			quo_q <= quo_nx;
			if (bit_q == '0) begin
				lev_q[ch_q] <= div_lev;
			end
		end

		if (state_q == ST_WRITE && out_free) begin
			out_data_q <= out_pack;
			out_user_q <= run_q;
		end
	end

endmodule
